// ===== hw/rtl/gpm_pkg.sv =====
package gpm_pkg;

    localparam int MAX_PATTERN = 32;

    localparam logic [7:0] SYM_ANY = 8'h3F;
    localparam logic [7:0] SYM_RUN = 8'h2A;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_BYTE   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] symbol;
    } in_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } out_t;

    // Per-transfer strobes broadcast from the top level to every cell.
    typedef struct packed {
        logic clear;
        logic append;
        logic consume;
        logic finish;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/gpm_cell.sv =====
module gpm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  gpm_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          symbol,
    input  logic                prev_valid,
    input  logic                next_valid,
    input  logic                closed_in,
    input  logic                stay_in,
    output logic                closed_out,
    output logic                stay_out,
    output logic                valid_out,
    output logic                active_out,
    output logic                hit
);

    logic [7:0] pat_reg;
    logic       valid_reg;
    logic       valid_next;
    logic       active_reg;
    logic       active_next;
    logic       is_star;
    logic       advance;
    logic       take_byte;

    assign is_star   = valid_reg && (pat_reg == gpm_pkg::SYM_RUN);
    assign take_byte = ctrl.append && prev_valid && !valid_reg;

    // The position after this cell is reached either directly or for free
    // through a star that the position before it reached.
    assign closed_out = active_reg | (closed_in & is_star);
    assign stay_out   = closed_in & is_star;
    assign advance    = closed_in && valid_reg && !is_star &&
                        ((pat_reg == gpm_pkg::SYM_ANY) || (pat_reg == symbol));

    // This cell marks the end of the pattern when the next one is empty.
    assign hit        = closed_out && valid_reg && !next_valid;
    assign valid_out  = valid_reg;
    assign active_out = active_reg;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (take_byte) begin
            valid_next = 1'b1;
        end
    end

    always_comb begin
        active_next = active_reg;
        if (ctrl.clear || ctrl.finish) begin
            active_next = 1'b0;
        end else if (ctrl.consume) begin
            active_next = advance | stay_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_byte) begin
            pat_reg <= symbol;
        end
    end

endmodule

// ===== hw/rtl/glob_pattern_matcher_core.sv =====
// Glob matcher: load a pattern with append commands ('?' matches any byte,
// '*' any run of bytes), stream candidate bytes, then send an end command to
// get one result with the match flag and the pattern overflow flag. A new
// transfer can be accepted every cycle unless a second result is waiting;
// the result of an end command is registered in an output register on the
// m_ channel, or in a skid register while that one is held, and is held
// until taken. The pattern lives in a row of MAX_PATTERN cells, each
// holding one pattern byte and one bit of the active position set; the free
// advance over consecutive stars ripples through the row within the cycle.
module glob_pattern_matcher_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gpm_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gpm_pkg::out_t m_data
);

    localparam int N = gpm_pkg::MAX_PATTERN;

    gpm_pkg::cell_ctrl_t ctrl;
    gpm_pkg::out_t       m_data_reg;
    logic                m_valid_reg;
    gpm_pkg::out_t       skid_data_reg;
    logic                skid_valid_reg;
    gpm_pkg::out_t       result;
    logic                s_accept;
    logic                active0_reg;
    logic                active0_next;
    logic                overflow_reg;
    logic                overflow_next;
    logic                matched;

    logic [N-1:0] valid_vec;
    logic [N-1:0] active_vec;
    logic [N-1:0] hit_vec;
    logic [N:0]   closed_vec;
    logic [N:0]   stay_vec;

    // A second result waits in the skid register while the first is held.
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        ctrl = '0;
        if (s_accept) begin
            unique case (s_data.command)
                gpm_pkg::CMD_CLEAR:  ctrl.clear   = 1'b1;
                gpm_pkg::CMD_APPEND: ctrl.append  = 1'b1;
                gpm_pkg::CMD_BYTE:   ctrl.consume = 1'b1;
                gpm_pkg::CMD_END:    ctrl.finish  = 1'b1;
                default:             ctrl = '0;
            endcase
        end
    end

    assign closed_vec[0] = active0_reg;
    assign stay_vec[N]   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            logic prev_v;
            logic next_v;
            if (gi == 0) begin : g_first
                assign prev_v = 1'b1;
            end else begin : g_mid
                assign prev_v = valid_vec[gi-1];
            end
            if (gi == N - 1) begin : g_last
                assign next_v = 1'b0;
            end else begin : g_inner
                assign next_v = valid_vec[gi+1];
            end
            gpm_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .symbol     (s_data.symbol),
                .prev_valid (prev_v),
                .next_valid (next_v),
                .closed_in  (closed_vec[gi]),
                .stay_in    (stay_vec[gi+1]),
                .closed_out (closed_vec[gi+1]),
                .stay_out   (stay_vec[gi]),
                .valid_out  (valid_vec[gi]),
                .active_out (active_vec[gi]),
                .hit        (hit_vec[gi])
            );
        end
    endgenerate

    // An empty pattern matches only when position zero is still active.
    assign matched = (|hit_vec) || (active0_reg && !valid_vec[0]);

    always_comb begin
        result.matched          = matched;
        result.pattern_overflow = overflow_reg;
    end

    always_comb begin
        active0_next = active0_reg;
        if (ctrl.clear || ctrl.finish) begin
            active0_next = 1'b1;
        end else if (ctrl.consume) begin
            active0_next = stay_vec[0];
        end
    end

    always_comb begin
        overflow_next = overflow_reg;
        if (ctrl.clear) begin
            overflow_next = 1'b0;
        end else if (ctrl.append && valid_vec[N-1]) begin
            overflow_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active0_reg    <= 1'b1;
            overflow_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            active0_reg  <= active0_next;
            overflow_reg <= overflow_next;
            if (!m_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= ctrl.finish;
                end
            end else if (ctrl.finish) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (ctrl.finish) begin
                m_data_reg <= result;
            end
        end else if (ctrl.finish) begin
            skid_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // Loaded cells always form a contiguous prefix of the row.
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + N'(1))) == '0)
        else $error("pattern cells are not a contiguous prefix");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.finish |=> m_valid)
        else $error("end of candidate gave no result");

    a_end_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.finish |=> (active0_reg && $countones(active_vec) == 0))
        else $error("active set not rearmed after end of candidate");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> (valid_vec == '0 && !overflow_reg && active0_reg))
        else $error("clear left pattern state behind");
`endif

endmodule
